[rtl/ptm_pkg.sv]
// ----------------------------------------------------------------------------
// ptm_pkg
// Types, constants and address helpers for the page-table MMU.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int PAGE_BYTES           = 256;
  localparam int PAGES                = 64;
  localparam int POINTER_TABLE_OFFSET = 64;
  localparam int PROCESSES            = 64;

  localparam int MEM_BYTES = PAGE_BYTES * PAGES;
  localparam int AW        = $clog2(MEM_BYTES);
  localparam int PW        = $clog2(PAGES + 1);

  typedef enum logic [1:0] {
    KIND_NEW   = 2'd0,
    KIND_KILL  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  process;
    logic [13:0] virtual_address;
    logic [7:0]  write_value;
    logic [5:0]  pages_wanted;
  } item_t;

  typedef struct packed {
    logic [13:0] physical_address;
    logic [7:0]  read_value;
    logic [5:0]  table_page;
    logic        out_of_memory;
  } result_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_N_RD,
    ST_N_CHK,
    ST_N_PTR,
    ST_N_ENT,
    ST_K_PRD,
    ST_K_PCHK,
    ST_K_ERD,
    ST_K_ECHK,
    ST_K_FREE,
    ST_T_PRD,
    ST_T_PCHK,
    ST_T_ECHK,
    ST_T_LD,
    ST_DONE
  } state_t;

  function automatic logic [AW-1:0] ptr_addr(input logic [5:0] proc);
    return AW'((POINTER_TABLE_OFFSET + (32'(proc) % PROCESSES)) % MEM_BYTES);
  endfunction

  function automatic logic [AW-1:0] entry_addr(input logic [7:0] tbl,
                                               input logic [PW-1:0] ix);
    return AW'((32'(tbl) * PAGE_BYTES + 32'(ix)) % MEM_BYTES);
  endfunction

  function automatic logic [PW-1:0] vpage_of(input logic [13:0] va);
    return PW'((32'(va) / PAGE_BYTES) % PAGES);
  endfunction

  function automatic logic [AW-1:0] data_byte_addr(input logic [7:0] entry,
                                                   input logic [13:0] va);
    return AW'(((32'(entry) % PAGES) * PAGE_BYTES + (32'(va) % PAGE_BYTES))
               % MEM_BYTES);
  endfunction

endpackage

[rtl/ptm_ram.sv]
// ----------------------------------------------------------------------------
// ptm_ram
// Single-port byte-wide physical memory with a registered read.
// ----------------------------------------------------------------------------
module ptm_ram (
  input  logic              clk,
  input  ptm_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import ptm_pkg::*;

  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

[rtl/ptm_seq.sv]
// ----------------------------------------------------------------------------
// ptm_seq
// Sequencer: clearing pass, first-fit allocation, kill sweep and translation,
// all as read and write steps on the physical memory.
// ----------------------------------------------------------------------------
module ptm_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ptm_pkg::item_t    item,
  output logic              res_valid,
  input  logic              res_take,
  output ptm_pkg::result_t  res,
  output ptm_pkg::mem_req_t mem_req,
  input  logic [7:0]        mem_rdata
);
  import ptm_pkg::*;

  state_t        state, state_next;
  logic [AW-1:0] clr_cnt;
  item_t         cur;
  logic [PW-1:0] p;
  logic [PW-1:0] idx;
  logic [7:0]    table_pg;
  logic          grab_tbl;

  logic [PW-1:0] p_inc;
  logic [PW-1:0] idx_inc;
  logic          p_end;
  logic          idx_end;
  logic          kill_hit;

  assign p_inc    = p + PW'(1);
  assign idx_inc  = idx + PW'(1);
  assign p_end    = (32'(p_inc) == PAGES);
  assign idx_end  = (idx_inc == PW'(cur.pages_wanted));
  assign kill_hit = (mem_rdata != 8'd0) && (32'(mem_rdata) < PAGES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:    if (clr_cnt == AW'(MEM_BYTES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item.kind)
            KIND_NEW:  state_next = ST_N_RD;
            KIND_KILL: state_next = ST_K_PRD;
            default:   state_next = ST_T_PRD;
          endcase
        end
      end
      ST_N_RD:   state_next = ST_N_CHK;
      ST_N_CHK: begin
        if (mem_rdata == 8'd0) begin
          state_next = grab_tbl ? ST_N_PTR : ST_N_ENT;
        end else if (p_end) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_N_RD;
        end
      end
      ST_N_PTR:  state_next = (cur.pages_wanted == 6'd0 || p_end) ? ST_DONE : ST_N_RD;
      ST_N_ENT:  state_next = (idx_end || p_end) ? ST_DONE : ST_N_RD;
      ST_K_PRD:  state_next = ST_K_PCHK;
      ST_K_PCHK: state_next = (mem_rdata == 8'd0) ? ST_DONE : ST_K_ERD;
      ST_K_ERD:  state_next = ST_K_ECHK;
      ST_K_ECHK: state_next = (32'(idx_inc) == PAGES) ? ST_K_FREE : ST_K_ERD;
      ST_K_FREE: state_next = ST_DONE;
      ST_T_PRD:  state_next = ST_T_PCHK;
      ST_T_PCHK: state_next = ST_T_ECHK;
      ST_T_ECHK: state_next = (cur.kind == KIND_LOAD) ? ST_T_LD : ST_DONE;
      ST_T_LD:   state_next = ST_DONE;
      ST_DONE:   if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs: memory request and handshake
  always_comb begin
    mem_req    = '0;
    item_stall = (state != ST_IDLE);
    res_valid  = (state == ST_DONE);
    unique case (state)
      ST_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt;
        mem_req.wdata = (clr_cnt == '0) ? 8'd1 : 8'd0;
      end
      ST_N_RD:   mem_req.addr = AW'(p);
      ST_N_CHK: begin
        mem_req.addr = AW'(p);
        if (mem_rdata == 8'd0) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = 8'd1;
        end
      end
      ST_N_PTR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ptr_addr(cur.process);
        mem_req.wdata = table_pg;
      end
      ST_N_ENT: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = entry_addr(table_pg, idx);
        mem_req.wdata = 8'(p);
      end
      ST_K_PRD:  mem_req.addr = ptr_addr(cur.process);
      ST_K_ERD:  mem_req.addr = entry_addr(table_pg, idx);
      ST_K_ECHK: begin
        mem_req.addr = AW'(mem_rdata);
        mem_req.we   = kill_hit;
      end
      ST_K_FREE: begin
        mem_req.addr = AW'(table_pg);
        mem_req.we   = (32'(table_pg) < PAGES);
      end
      ST_T_PRD:  mem_req.addr = ptr_addr(cur.process);
      ST_T_PCHK: mem_req.addr = entry_addr(mem_rdata, vpage_of(cur.virtual_address));
      ST_T_ECHK: begin
        mem_req.addr  = data_byte_addr(mem_rdata, cur.virtual_address);
        mem_req.we    = (cur.kind == KIND_STORE);
        mem_req.wdata = cur.write_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cur      <= item;
          res      <= '0;
          p        <= '0;
          idx      <= '0;
          grab_tbl <= 1'b1;
        end
      end
      ST_N_CHK: begin
        if (mem_rdata != 8'd0) begin
          p <= p_inc;
          if (p_end) res.out_of_memory <= 1'b1;
        end else if (grab_tbl) begin
          table_pg <= 8'(p);
        end
      end
      ST_N_PTR: begin
        grab_tbl       <= 1'b0;
        res.table_page <= 6'(p);
        p              <= p_inc;
        if (cur.pages_wanted != 6'd0 && p_end) res.out_of_memory <= 1'b1;
      end
      ST_N_ENT: begin
        idx <= idx_inc;
        p   <= p_inc;
        if (!idx_end && p_end) res.out_of_memory <= 1'b1;
      end
      ST_K_PCHK: begin
        table_pg <= mem_rdata;
        idx      <= '0;
      end
      ST_K_ECHK: idx <= idx_inc;
      ST_T_ECHK: res.physical_address <= 14'(data_byte_addr(mem_rdata, cur.virtual_address));
      ST_T_LD:   res.read_value <= mem_rdata;
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state != ST_IDLE && state != ST_CLR))
    else $error("accepted transfer did not start work");

  a_done_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !mem_req.we)
    else $error("memory write while result pending");

  a_oom_new_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res.out_of_memory) |-> (cur.kind == KIND_NEW))
    else $error("out_of_memory on non-allocating item");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_N_RD) |-> (32'(p) < PAGES))
    else $error("free-map scan beyond last page");

endmodule

[rtl/page_table_mmu_with_free_map.sv]
// ----------------------------------------------------------------------------
// page_table_mmu_with_free_map
// Single-level page table MMU with a first-fit page free map in one memory.
//
// Items arrive on item/item_valid/item_stall; one result per item leaves on
// result/result_valid/result_stall. A transfer happens when valid is high
// and stall is low.
// After reset the memory is swept once, one byte a cycle, and
// item_stall stays high throughout. Afterwards byte 0 holds 1, all else 0.
// Each item is worked through as steps, each one access to the single-port
// memory: a new process probes free-map bytes and takes pages, writing its
// pointer and one table entry per page; a kill reads the pointer and, if a
// table is set, every entry, freeing the pages named and then the table
// page; a load or store reads pointer and entry, then accesses the data byte.
// One item is worked on at a time. The result sits in an output register,
// so a new item is taken while an earlier result waits; if the receiver
// stalls and the next result is ready, the sequencer holds until it drains.
// ----------------------------------------------------------------------------
module page_table_mmu_with_free_map (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ptm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ptm_pkg::result_t result
);
  import ptm_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       res_valid;
  logic       res_take;
  result_t    res;

  ptm_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ptm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  assign res_take = res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result <= res;
    end
  end

endmodule

[bench/mmu_result_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmu_result_check
// Watches both channels of the page-table MMU. Each item transfer is run
// through a local copy of the physical memory (free map, process pointers,
// page tables and data pages) to work out the result the block should give;
// each result transfer is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module mmu_result_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  ptm_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  ptm_pkg::result_t result,
  output int               fails,
  output int               pending
);
  import ptm_pkg::*;

  logic [7:0] shadow_mem [0:MEM_BYTES-1];
  result_t    results_due[$];
  int         errors = 0;
  int         k;

  function automatic int pointer_slot(input logic [5:0] proc);
    return (POINTER_TABLE_OFFSET + int'(proc) % PROCESSES) % MEM_BYTES;
  endfunction

  // first-fit scan of the free map
  function automatic int take_page();
    int p;
    for (p = 0; p < PAGES; p++) begin
      if (shadow_mem[p] == 8'd0) begin
        shadow_mem[p] = 8'd1;
        return p;
      end
    end
    return -1;
  endfunction

  function automatic result_t apply_item(input item_t it);
    result_t r;
    int      tbl, pg, e, a, vpg, i;
    r = '0;
    case (it.kind)
      KIND_NEW: begin
        tbl = take_page();
        if (tbl < 0) begin
          r.out_of_memory = 1'b1;
        end else begin
          shadow_mem[pointer_slot(it.process)] = 8'(tbl);
          r.table_page = 6'(tbl);
          i = 0;
          while (i < int'(it.pages_wanted) && !r.out_of_memory) begin
            pg = take_page();
            if (pg < 0) r.out_of_memory = 1'b1;
            else shadow_mem[(tbl * PAGE_BYTES + i) % MEM_BYTES] = 8'(pg);
            i++;
          end
        end
      end
      KIND_KILL: begin
        tbl = shadow_mem[pointer_slot(it.process)];
        if (tbl != 0) begin
          for (i = 0; i < PAGES; i++) begin
            e = shadow_mem[(tbl * PAGE_BYTES + i) % MEM_BYTES];
            if (e != 0 && e < PAGES) shadow_mem[e] = 8'd0;
          end
          if (tbl < PAGES) shadow_mem[tbl] = 8'd0;
        end
      end
      default: begin
        vpg = (int'(it.virtual_address) / PAGE_BYTES) % PAGES;
        tbl = shadow_mem[pointer_slot(it.process)];
        e   = shadow_mem[(tbl * PAGE_BYTES + vpg) % MEM_BYTES];
        a   = ((e % PAGES) * PAGE_BYTES + int'(it.virtual_address) % PAGE_BYTES) % MEM_BYTES;
        r.physical_address = 14'(a);
        if (it.kind == KIND_STORE) shadow_mem[a] = it.write_value;
        else r.read_value = shadow_mem[a];
      end
    endcase
    return r;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (results_due.size() == 0) begin
      if (errors < 10)
        $display("%0t: result with none due: addr %h rd %h table %0d oom %b", $time,
                 got.physical_address, got.read_value, got.table_page, got.out_of_memory);
      errors++;
    end else begin
      want = results_due.pop_front();
      if (got.physical_address !== want.physical_address ||
          got.read_value !== want.read_value ||
          got.table_page !== want.table_page ||
          got.out_of_memory !== want.out_of_memory) begin
        if (errors < 10)
          $display("%0t: expected addr %h rd %h tbl %0d oom %b, got addr %h rd %h tbl %0d oom %b",
                   $time, want.physical_address, want.read_value, want.table_page,
                   want.out_of_memory, got.physical_address, got.read_value,
                   got.table_page, got.out_of_memory);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (k = 0; k < MEM_BYTES; k++) shadow_mem[k] = 8'd0;
      shadow_mem[0] = 8'd1;
      results_due.delete();
      pending <= 0;
    end else begin
      // a result never belongs to an item taken at the same edge
      if (result_valid && !result_stall) check_result(result);
      if (item_valid && !item_stall) results_due.push_back(apply_item(item));
      pending <= results_due.size();
      fails   <= errors;
    end
  end

endmodule

[bench/tb_page_table_mmu_with_free_map.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_table_mmu_with_free_map
// Drives the MMU with a directed run through allocation, exhaustion, kill,
// translation and stray table entries, then random process lifecycles with
// random loads and stores, under several sender idle and receiver stall
// mixes. Checking is done by mmu_result_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_page_table_mmu_with_free_map;
  import ptm_pkg::*;

  localparam int QUIET_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 125;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  int fails;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;
  int phase;

  bit alive      [PROCESSES];
  int data_pages [PROCESSES];

  always #5 clk = ~clk;

  page_table_mmu_with_free_map dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  mmu_result_check result_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fails        (fails),
    .pending      (pending)
  );

  always @(posedge clk) begin
    result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic item_t item_of(input kind_t k, input logic [5:0] proc,
                                    input logic [13:0] va, input logic [7:0] wv,
                                    input logic [5:0] pw);
    item_t it;
    it.kind            = k;
    it.process         = proc;
    it.virtual_address = va;
    it.write_value     = wv;
    it.pages_wanted    = pw;
    return it;
  endfunction

  // Mostly whole lifecycles on processes 0..3 and 60..63; a few stray items.
  function automatic item_t next_random_item();
    item_t it;
    int    p, pw, sel;
    it.kind            = KIND_LOAD;
    it.process         = 6'($urandom);
    it.virtual_address = 14'($urandom);
    it.write_value     = 8'($urandom);
    it.pages_wanted    = 6'($urandom);
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(2))
        0: it.kind = KIND_KILL;
        1: it.kind = KIND_STORE;
        default: it.kind = KIND_LOAD;
      endcase
      if (it.kind == KIND_KILL) alive[it.process] = 1'b0;
      return it;
    end
    p = $urandom_range(7);
    if (p >= 4) p = p + 56;
    it.process = 6'(p);
    if (!alive[p]) begin
      it.kind = KIND_NEW;
      pw = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(6, 1);
      it.pages_wanted = 6'(pw);
      alive[p]      = 1'b1;
      data_pages[p] = pw;
    end else begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        it.kind  = KIND_KILL;
        alive[p] = 1'b0;
      end else begin
        it.kind = (sel < 56) ? KIND_STORE : KIND_LOAD;
        if (data_pages[p] > 0 && $urandom_range(9) != 0)
          it.virtual_address = 14'($urandom_range(data_pages[p] - 1) * PAGE_BYTES +
                                   $urandom_range(PAGE_BYTES - 1));
      end
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // hold off until every result due has been taken
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(item_of(KIND_LOAD,  6'd0,  14'h0000, 8'h00, 6'd0));   // no table yet
    send_item(item_of(KIND_KILL,  6'd5,  14'h0000, 8'h00, 6'd0));   // kill, no table
    send_item(item_of(KIND_NEW,   6'd63, 14'h0000, 8'h00, 6'd0));   // no data pages
    send_item(item_of(KIND_NEW,   6'd0,  14'h0000, 8'h00, 6'd3));
    send_item(item_of(KIND_STORE, 6'd0,  14'h02ff, 8'hff, 6'd0));
    send_item(item_of(KIND_STORE, 6'd0,  14'h0100, 8'ha5, 6'd0));
    send_item(item_of(KIND_LOAD,  6'd0,  14'h02ff, 8'h00, 6'd0));
    send_item(item_of(KIND_LOAD,  6'd0,  14'h0100, 8'h00, 6'd0));
    send_item(item_of(KIND_LOAD,  6'd0,  14'h3fff, 8'h00, 6'd63));  // beyond allocation
    send_item(item_of(KIND_STORE, 6'd63, 14'h3fff, 8'hff, 6'd63));
    send_item(item_of(KIND_NEW,   6'd1,  14'h3fff, 8'hff, 6'd63));  // data pages run out
    send_item(item_of(KIND_NEW,   6'd2,  14'h0000, 8'h00, 6'd1));   // no table page left
    send_item(item_of(KIND_LOAD,  6'd1,  14'h3eff, 8'h00, 6'd0));
    send_item(item_of(KIND_KILL,  6'd1,  14'h0000, 8'h00, 6'd0));
    send_item(item_of(KIND_KILL,  6'd1,  14'h0000, 8'h00, 6'd0));   // stale pointer
    send_item(item_of(KIND_KILL,  6'd0,  14'h0000, 8'h00, 6'd0));
    send_item(item_of(KIND_KILL,  6'd63, 14'h0000, 8'h00, 6'd0));
    send_item(item_of(KIND_KILL,  6'd2,  14'h0000, 8'h00, 6'd0));
    send_item(item_of(KIND_NEW,   6'd3,  14'h0000, 8'h00, 6'd2));
    // tableless process maps through the free map onto page 1: plant a wide entry
    send_item(item_of(KIND_STORE, 6'd40, 14'h0102, 8'd200, 6'd0));
    send_item(item_of(KIND_LOAD,  6'd3,  14'h0234, 8'h00, 6'd0));
    send_item(item_of(KIND_KILL,  6'd3,  14'h0000, 8'h00, 6'd0));
    settle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 71; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 71; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      repeat (PHASE_ITEMS) send_item(next_random_item());
      settle();
    end

    stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
